[rtl/core/afnt_pkg.sv]
// Package for the aspect-fit nearest-neighbor thumbnail block.
// Holds sizes, command and register codes, payload structs and the divider interface.
// No dependencies.
package afnt_pkg;

    // Store and geometry limits
    localparam int MAX_TIP_SIDE  = 256;
    localparam int MAX_CELL_SIDE = 256;
    localparam int STORE_SIZE    = MAX_TIP_SIDE * MAX_TIP_SIDE;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int SIDE_W        = 9;
    localparam int COORD_W       = 8;
    localparam int PIX_W         = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIP_HEIGHT = 2'd2;
    localparam logic [SIDE_W-1:0]    CELL_SIDE_RESET = 9'd64;

    // Commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    // Shared divider sizes: numerator covers 2*short*side + long
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic [1:0]         command;
        logic [PIX_W-1:0]   sample_coverage;
        logic [COORD_W-1:0] query_x;
        logic [COORD_W-1:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/core/afnt_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on afnt_pkg for widths and the request/response structs.
module afnt_div
    import afnt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_shift;
    logic                 w_fit;

    // Shift in the next numerator bit and trial-subtract
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= DIV_DEN_W'(w_shift - {1'b0, r_den});
            end else begin
                r_rem <= w_shift[DIV_DEN_W-1:0];
            end
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

[rtl/core/aspect_fit_nearest_thumbnail.sv]
// Aspect-fit nearest-neighbor thumbnail over a stored 8-bit coverage mask.
// Depends on afnt_pkg and afnt_div (shared sequential divider).
//
// Input channel (i_in_valid / o_in_stall, i_in_data): clear resets the sample
//   count, append writes one coverage byte at the next row-major address, query
//   asks for one RGBA pixel. Output channel (o_out_valid / i_out_stall,
//   o_out_data) returns one pixel per query; clear and append return nothing.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set cell side, mask
//   width and mask height; write them only while the block is idle.
// Clear and append are taken while idle and leave the sequencer idle. A query that
//   reaches the memory runs three divider passes of 18 quotient bits each for the
//   short drawn side, the sample column and the sample row, plus eight setup,
//   address, read and handoff steps; the next transaction can be accepted in the
//   same cycle that the pixel becomes valid. Early rejects (outside the cell, bad
//   size, count mismatch) skip all divider passes, drawn-area misses run only the first.
// A finished pixel waits in the output register while the receiver stalls; the
//   next transaction is accepted meanwhile, and a following query parks in its
//   last step until the register frees up.
// Reset: sample count clears, cell side returns to 64, mask size to zero; the
//   coverage memory is not cleared, entries are valid once appended.
module aspect_fit_nearest_thumbnail
    import afnt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GEO  = 4'd1;
    localparam logic [3:0] S_NUM  = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_OFF  = 4'd4;
    localparam logic [3:0] S_IN   = 4'd5;
    localparam logic [3:0] S_SX   = 4'd6;
    localparam logic [3:0] S_DIVX = 4'd7;
    localparam logic [3:0] S_DIVY = 4'd8;
    localparam logic [3:0] S_ADDR = 4'd9;
    localparam logic [3:0] S_RD   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]            r_state;
    logic [3:0]            n_state;

    // Configuration and sample count
    logic [SIDE_W-1:0]     r_cell;
    logic [SIDE_W-1:0]     r_tw;
    logic [SIDE_W-1:0]     r_th;
    logic [CNT_W-1:0]      r_count;

    // Coverage memory
    logic [PIX_W-1:0]      mem_cov [0:STORE_SIZE-1];
    logic [PIX_W-1:0]      r_rd_data;

    // Query working registers
    logic [COORD_W-1:0]    r_qx;
    logic [COORD_W-1:0]    r_qy;
    logic [SIDE_W-1:0]     r_side;
    logic                  r_bad;
    logic                  r_hit;
    logic                  r_wide;
    logic [SIDE_W-1:0]     r_long;
    logic [2*SIDE_W-1:0]   r_wh;
    logic [2*SIDE_W-1:0]   r_sh;
    logic [SIDE_W-1:0]     r_dw;
    logic [SIDE_W-1:0]     r_dh;
    logic [COORD_W-1:0]    r_ox;
    logic [COORD_W-1:0]    r_oy;
    logic [COORD_W+SIDE_W-1:0] r_px;
    logic [COORD_W+SIDE_W-1:0] r_py;
    logic [COORD_W-1:0]    r_sx;
    logic [COORD_W-1:0]    r_sy;
    logic [ADDR_W-1:0]     r_addr;

    // Output register
    logic                  r_out_valid;
    t_out_item             r_out;

    // Combinational helpers
    logic                  w_in_acc;
    logic                  w_out_free;
    logic [SIDE_W-1:0]     w_side;
    logic [SIDE_W-1:0]     w_short;
    logic [SIDE_W-1:0]     w_quot;
    logic [SIDE_W-1:0]     w_dshort;
    logic [SIDE_W:0]       w_xend;
    logic [SIDE_W:0]       w_yend;
    logic                  w_inside;
    logic [SIDE_W-1:0]     w_tw_m1;
    logic [SIDE_W-1:0]     w_th_m1;
    logic [COORD_W-1:0]    w_sel_x;
    logic [COORD_W-1:0]    w_sel_y;
    logic [COORD_W+SIDE_W-1:0] w_row_base;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Clamp cell side into 1..MAX_CELL_SIDE
    always_comb begin
        if (r_cell == '0) begin
            w_side = SIDE_W'(1);
        end else if (r_cell > SIDE_W'(MAX_CELL_SIDE)) begin
            w_side = SIDE_W'(MAX_CELL_SIDE);
        end else begin
            w_side = r_cell;
        end
    end

    assign w_short  = (r_tw >= r_th) ? r_th : r_tw;
    assign w_quot   = w_div_rsp.quot[SIDE_W-1:0];
    assign w_dshort = (w_quot == '0) ? SIDE_W'(1) : w_quot;

    // Drawn-area window test
    assign w_xend   = {2'b00, r_ox} + {1'b0, r_dw};
    assign w_yend   = {2'b00, r_oy} + {1'b0, r_dh};
    assign w_inside = (r_qx >= r_ox) && ({2'b00, r_qx} < w_xend)
                   && (r_qy >= r_oy) && ({2'b00, r_qy} < w_yend);

    // Clamp sample index to the last column or row
    assign w_tw_m1 = r_tw - 1'b1;
    assign w_th_m1 = r_th - 1'b1;
    assign w_sel_x = (w_quot > w_tw_m1) ? w_tw_m1[COORD_W-1:0] : w_quot[COORD_W-1:0];
    assign w_sel_y = (w_quot > w_th_m1) ? w_th_m1[COORD_W-1:0] : w_quot[COORD_W-1:0];

    assign w_row_base = (COORD_W+SIDE_W)'(r_sy) * (COORD_W+SIDE_W)'(r_tw);

    // Divider requests: short drawn side, then sample column, then sample row
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            S_NUM: begin
                w_div_req.start = !(r_bad || ({1'b0, r_count} != r_wh));
                w_div_req.num   = {r_sh[DIV_NUM_W-2:0], 1'b0} + DIV_NUM_W'(r_long);
                w_div_req.den   = {r_long, 1'b0};
            end
            S_SX: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = DIV_NUM_W'(r_px);
                w_div_req.den   = DIV_DEN_W'(r_dw);
            end
            S_DIVX: begin
                w_div_req.start = w_div_rsp.done;
                w_div_req.num   = DIV_NUM_W'(r_py);
                w_div_req.den   = DIV_DEN_W'(r_dh);
            end
            default: begin
                w_div_req = '0;
            end
        endcase
    end

    afnt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_data.command == CMD_QUERY)) begin
                    n_state = S_GEO;
                end
            end
            S_GEO:  n_state = S_NUM;
            S_NUM:  n_state = w_div_req.start ? S_DIV1 : S_DONE;
            S_DIV1: n_state = w_div_rsp.done ? S_OFF : S_DIV1;
            S_OFF:  n_state = S_IN;
            S_IN:   n_state = w_inside ? S_SX : S_DONE;
            S_SX:   n_state = S_DIVX;
            S_DIVX: n_state = w_div_rsp.done ? S_DIVY : S_DIVX;
            S_DIVY: n_state = w_div_rsp.done ? S_ADDR : S_DIVY;
            S_ADDR: n_state = S_RD;
            S_RD:   n_state = S_DONE;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: state, configuration, sample count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell      <= CELL_SIDE_RESET;
            r_tw        <= '0;
            r_th        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CELL_SIDE:  r_cell <= i_cfg_data;
                    CFG_TIP_WIDTH:  r_tw   <= i_cfg_data;
                    CFG_TIP_HEIGHT: r_th   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                if (i_in_data.command == CMD_CLEAR) begin
                    r_count <= '0;
                end else if ((i_in_data.command == CMD_APPEND)
                          && (r_count <= CNT_W'(STORE_SIZE))) begin
                    r_count <= r_count + 1'b1;
                end
            end
            // Hand over a finished pixel, drop valid once taken
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Coverage memory: append writes, one registered read per query
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.command == CMD_APPEND)
                && (r_count < CNT_W'(STORE_SIZE))) begin
            mem_cov[r_count[ADDR_W-1:0]] <= i_in_data.sample_coverage;
        end
        if (r_state == S_RD) begin
            r_rd_data <= mem_cov[r_addr];
        end
    end

    // Query datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qx  <= i_in_data.query_x;
                r_qy  <= i_in_data.query_y;
                r_hit <= 1'b0;
            end
            S_GEO: begin
                r_side <= w_side;
                r_bad  <= ({1'b0, r_qx} >= w_side) || ({1'b0, r_qy} >= w_side)
                       || (r_tw == '0) || (r_th == '0)
                       || (r_tw > SIDE_W'(MAX_TIP_SIDE))
                       || (r_th > SIDE_W'(MAX_TIP_SIDE));
                r_wh   <= (2*SIDE_W)'(r_tw) * (2*SIDE_W)'(r_th);
                r_wide <= (r_tw >= r_th);
                r_long <= (r_tw >= r_th) ? r_tw : r_th;
                r_sh   <= (2*SIDE_W)'(w_short) * (2*SIDE_W)'(w_side);
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    r_dw <= r_wide ? r_side : w_dshort;
                    r_dh <= r_wide ? w_dshort : r_side;
                end
            end
            S_OFF: begin
                r_ox <= COORD_W'((r_side - r_dw) >> 1);
                r_oy <= COORD_W'((r_side - r_dh) >> 1);
            end
            S_IN: begin
                r_px <= (COORD_W+SIDE_W)'(r_qx - r_ox) * (COORD_W+SIDE_W)'(r_tw);
                r_py <= (COORD_W+SIDE_W)'(r_qy - r_oy) * (COORD_W+SIDE_W)'(r_th);
            end
            S_DIVX: begin
                if (w_div_rsp.done) begin
                    r_sx <= w_sel_x;
                end
            end
            S_DIVY: begin
                if (w_div_rsp.done) begin
                    r_sy <= w_sel_y;
                end
            end
            S_ADDR: begin
                r_addr <= ADDR_W'(w_row_base + (COORD_W+SIDE_W)'(r_sx));
            end
            S_RD: begin
                r_hit <= 1'b1;
            end
            default: ;
        endcase
        // Load the output register with white plus coverage, or all zero
        if ((r_state == S_DONE) && w_out_free) begin
            if (r_hit) begin
                r_out.red   <= PIX_FULL;
                r_out.green <= PIX_FULL;
                r_out.blue  <= PIX_FULL;
                r_out.alpha <= r_rd_data;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sample count never runs past the saturation point
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_SIZE + 1))
        else $error("sample count above saturation");

    // Divider only finishes while a division is awaited
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV1) || (r_state == S_DIVX)
                           || (r_state == S_DIVY))
        else $error("divider result with no division pending");

    // A waiting pixel is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result finished while output register still full");

    // An accepted query starts the geometry step
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.command == CMD_QUERY) |=> (r_state == S_GEO))
        else $error("accepted query did not start");

endmodule
